// ===== sv/ttm_pkg.sv =====
package ttm_pkg;

   localparam int IDX_W = 10;
   localparam int VAL_W = 31;
   localparam int CNT_W = 11;
   localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

   typedef struct packed {
      logic [IDX_W-1:0] leaf_index;
      logic [VAL_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] top_index;
      logic [VAL_W-1:0] top_value;
      logic             index_error;
   } rsp_type;

   typedef enum logic [4:0] {
      S_CLRI, S_CLEAR, S_SHAPE, S_SDIV, S_SNEXT, S_IDLE,
      S_UCHK, S_UDIV, S_USI, S_USCAN, S_UWAIT, S_UINC, S_UWR,
      S_DWANT, S_DCAP, S_DDEC, S_DSI, S_DSCAN, S_DWAIT, S_DNEXT, S_DONE
   } state_type;

   typedef struct packed {
      logic cfg_write;
      logic clr_init;
      logic clr_step;
      logic div_shape;
      logic div_pos;
      logic div_step;
      logic shape_next;
      logic shape_end;
      logic item_load;
      logic up_init;
      logic scan_step;
      logic up_inc;
      logic up_write;
      logic dn_init;
      logic dn_want;
      logic dn_cap;
      logic dn_dec;
      logic dn_init_scan;
      logic dn_next;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic size_gt1;
      logic scan_last;
      logic up_more;
      logic dn_more;
      logic err;
   } sts_type;

endpackage

// ===== sv/ttm_ram.sv =====
module ttm_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/ttm_ctrl.sv =====
module ttm_ctrl
   import ttm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  logic    csr_valid,
   output logic    csr_ready,
   output logic    rsp_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLRI;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = (state_ff != S_IDLE);
      csr_ready = (state_ff == S_IDLE) && !start;
      rsp_valid = (state_ff == S_DONE);
      case (state_ff)
         S_CLRI: begin
            cmd.clr_init = 1'b1;
            state_in = S_CLEAR;
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clear_done) state_in = S_SHAPE;
         end
         S_SHAPE: begin
            if (sts.size_gt1) begin
               cmd.div_shape = 1'b1;
               state_in = S_SDIV;
            end else begin
               cmd.shape_end = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SDIV: begin
            cmd.div_step = 1'b1;
            state_in = S_SNEXT;
         end
         S_SNEXT: begin
            cmd.shape_next = 1'b1;
            state_in = S_SHAPE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.item_load = 1'b1;
               state_in = S_UCHK;
            end else if (csr_valid) begin
               cmd.cfg_write = 1'b1;
               state_in = S_CLRI;
            end
         end
         S_UCHK: begin
            if (!sts.err && sts.up_more) begin
               cmd.div_pos = 1'b1;
               state_in = S_UDIV;
            end else begin
               cmd.dn_init = 1'b1;
               state_in = S_DWANT;
            end
         end
         S_UDIV: begin
            cmd.div_step = 1'b1;
            state_in = S_USI;
         end
         S_USI: begin
            cmd.up_init = 1'b1;
            state_in = S_USCAN;
         end
         S_USCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_UWAIT;
         end
         S_UWAIT: begin
            state_in = S_UINC;
         end
         S_UINC: begin
            cmd.up_inc = 1'b1;
            state_in = S_UWR;
         end
         S_UWR: begin
            cmd.up_write = 1'b1;
            state_in = S_UCHK;
         end
         S_DWANT: begin
            cmd.dn_want = 1'b1;
            state_in = S_DCAP;
         end
         S_DCAP: begin
            cmd.dn_cap = 1'b1;
            state_in = sts.dn_more ? S_DDEC : S_DONE;
         end
         S_DDEC: begin
            cmd.dn_dec = 1'b1;
            state_in = S_DSI;
         end
         S_DSI: begin
            cmd.dn_init_scan = 1'b1;
            state_in = S_DSCAN;
         end
         S_DSCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_DWAIT;
         end
         S_DWAIT: begin
            state_in = S_DNEXT;
         end
         S_DNEXT: begin
            cmd.dn_next = 1'b1;
            state_in = S_DWANT;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLRI;
         end
      endcase
   end

endmodule

// ===== sv/ttm_dp.sv =====
module ttm_dp
   import ttm_pkg::*;
#(
   parameter int LEAVES = 1024,
   parameter int FANOUT = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  req_type          req_data,
   input  logic [CNT_W-1:0] csr_data,
   output rsp_type          rsp_data
);

   localparam int CW    = $clog2(LEAVES + 1);
   localparam int DEPTH = 2 * LEAVES;
   localparam int AW    = $clog2(DEPTH);
   localparam int NL    = $clog2(LEAVES) + 2;
   localparam int LVW   = $clog2(NL);
   localparam int RW    = $clog2(FANOUT) + 1;
   localparam int TW    = CW + RW;
   localparam int MW    = CW + 2;
   localparam int PW    = CW + MW;
   localparam int SH    = CW + $clog2(FANOUT);
   // divide by FANOUT as a multiply by its rounded-up reciprocal
   localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'(FANOUT) - 64'd1) / 64'(FANOUT));

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [AW-1:0]    i_ff, i_in, end_ff, end_in, cb_ff, cb_in, ri_ff, ri_in;
   logic [AW-1:0]    runb_ff, runb_in;
   logic             vld_ff, up_ff, up_in, found_ff, found_in, err_ff, err_in;
   logic [LVW-1:0]   lev_ff, lev_in, top_lev_ff, top_lev_in;
   logic [CW-1:0]    size_ff [NL];
   logic [CW-1:0]    size_in [NL];
   logic [AW-1:0]    base_ff [NL];
   logic [AW-1:0]    base_in [NL];
   logic [CW-1:0]    dq_ff, dq_in, pos_ff, pos_in, top_ff, top_in, tnew_ff, tnew_in;
   logic [RW-1:0]    dr_ff, dr_in;
   logic [VAL_W-1:0] max_ff, max_in, want_ff, want_in, root_ff, root_in;

   logic [CW-1:0]    cur_size, clip_n, s_val;
   logic [AW-1:0]    cur_base;
   logic [TW-1:0]    t_val;
   logic [PW-1:0]    prod;
   logic [CW-1:0]    quo;
   logic [AW-1:0]    ram_addr;
   logic             ram_we;
   logic [VAL_W-1:0] ram_wd, ram_rd;
   logic             idx_bad;

   assign cur_size = size_ff[lev_ff];
   assign cur_base = base_ff[lev_ff];
   assign idx_bad  = 32'(req_data.leaf_index) >= 32'(n_ff);
   assign prod     = PW'(dq_ff) * PW'(RECIP);
   assign quo      = CW'(prod >> SH);

   always_comb begin
      if (cnt_ff == '0) begin
         clip_n = CW'(1);
      end else if (32'(cnt_ff) > 32'(LEAVES)) begin
         clip_n = CW'(LEAVES);
      end else begin
         clip_n = CW'(cnt_ff);
      end
   end

   always_comb begin
      if (cmd.up_init) begin
         s_val = pos_ff - CW'(dr_ff);
      end else begin
         s_val = CW'(TW'(top_ff) * TW'(FANOUT));
      end
      t_val = TW'(s_val) + TW'(FANOUT);
      if (t_val > TW'(cur_size)) t_val = TW'(cur_size);
   end

   always_comb begin
      cnt_in     = cnt_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      end_in     = end_ff;
      cb_in      = cb_ff;
      ri_in      = ri_ff;
      runb_in    = runb_ff;
      up_in      = up_ff;
      found_in   = found_ff;
      err_in     = err_ff;
      lev_in     = lev_ff;
      top_lev_in = top_lev_ff;
      size_in    = size_ff;
      base_in    = base_ff;
      dq_in      = dq_ff;
      dr_in      = dr_ff;
      pos_in     = pos_ff;
      top_in     = top_ff;
      tnew_in    = tnew_ff;
      max_in     = max_ff;
      want_in    = want_ff;
      root_in    = root_ff;
      ram_addr   = i_ff;
      ram_we     = 1'b0;
      ram_wd     = '0;

      if (cmd.cfg_write) cnt_in = csr_data;
      if (cmd.clr_init) begin
         i_in       = '0;
         lev_in     = '0;
         n_in       = clip_n;
         size_in[0] = clip_n;
         base_in[0] = '0;
         runb_in    = AW'(LEAVES);
      end
      if (cmd.clr_step) begin
         ram_we = 1'b1;
         i_in   = i_ff + 1'b1;
      end
      if (cmd.div_shape || cmd.div_pos) begin
         dq_in   = cmd.div_shape ? cur_size - 1'b1 : pos_ff;
         dr_in   = '0;
      end
      if (cmd.div_step) begin
         dq_in = quo;
         dr_in = RW'(TW'(dq_ff) - TW'(quo) * TW'(FANOUT));
      end
      if (cmd.shape_next) begin
         size_in[LVW'(lev_ff + 1'b1)] = dq_ff + 1'b1;
         base_in[LVW'(lev_ff + 1'b1)] = runb_ff;
         runb_in = runb_ff + AW'(dq_ff) + 1'b1;
         lev_in  = lev_ff + 1'b1;
      end
      if (cmd.shape_end) top_lev_in = lev_ff;
      if (cmd.item_load) begin
         pos_in   = CW'(req_data.leaf_index);
         lev_in   = '0;
         err_in   = idx_bad;
         ram_addr = AW'(req_data.leaf_index);
         ram_we   = !idx_bad;
         ram_wd   = req_data.new_value;
      end
      if (cmd.up_init || cmd.dn_init_scan) begin
         i_in     = AW'(s_val);
         end_in   = AW'(t_val);
         cb_in    = cur_base;
         max_in   = '0;
         found_in = 1'b0;
         tnew_in  = top_ff;
         up_in    = cmd.up_init;
      end
      if (cmd.scan_step) begin
         ram_addr = cb_ff + i_ff;
         ri_in    = i_ff;
         i_in     = i_ff + 1'b1;
      end
      if (vld_ff) begin
         if (up_ff) begin
            if (ram_rd > max_ff) max_in = ram_rd;
         end else if (!found_ff && ram_rd == want_ff) begin
            found_in = 1'b1;
            tnew_in  = CW'(ri_ff);
         end
      end
      if (cmd.up_inc) begin
         lev_in = lev_ff + 1'b1;
         pos_in = dq_ff;
      end
      if (cmd.up_write) begin
         ram_addr = cur_base + AW'(pos_ff);
         ram_we   = 1'b1;
         ram_wd   = max_ff;
      end
      if (cmd.dn_init) begin
         lev_in = top_lev_ff;
         top_in = '0;
      end
      if (cmd.dn_want) ram_addr = cur_base + AW'(top_ff);
      if (cmd.dn_cap) begin
         want_in = ram_rd;
         if (lev_ff == top_lev_ff) root_in = ram_rd;
      end
      if (cmd.dn_dec) lev_in = lev_ff - 1'b1;
      if (cmd.dn_next) top_in = tnew_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_RESET;
         vld_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         vld_ff <= cmd.scan_step;
      end
      n_ff       <= n_in;
      i_ff       <= i_in;
      end_ff     <= end_in;
      cb_ff      <= cb_in;
      ri_ff      <= ri_in;
      runb_ff    <= runb_in;
      up_ff      <= up_in;
      found_ff   <= found_in;
      err_ff     <= err_in;
      lev_ff     <= lev_in;
      top_lev_ff <= top_lev_in;
      size_ff    <= size_in;
      base_ff    <= base_in;
      dq_ff      <= dq_in;
      dr_ff      <= dr_in;
      pos_ff     <= pos_in;
      top_ff     <= top_in;
      tnew_ff    <= tnew_in;
      max_ff     <= max_in;
      want_ff    <= want_in;
      root_ff    <= root_in;
   end

   ttm_ram #(
      .WIDTH(VAL_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wd),
      .rdata(ram_rd)
   );

   assign sts.clear_done = (i_ff == AW'(DEPTH - 1));
   assign sts.size_gt1   = (cur_size > CW'(1));
   assign sts.scan_last  = (i_ff + 1'b1 == end_ff);
   assign sts.up_more    = (lev_ff != top_lev_ff);
   assign sts.dn_more    = (lev_ff != '0);
   assign sts.err        = err_ff;

   assign rsp_data.top_index   = IDX_W'(top_ff);
   assign rsp_data.top_value   = root_ff;
   assign rsp_data.index_error = err_ff;

endmodule

// ===== sv/eight_way_max_tournament_tree.sv =====
// Eight-way max tournament tree: maxima over groups of FANOUT leaves, level by level.
// Input: pulse start with req_data while busy is low; the beat writes one leaf
// (ignored and flagged when the index is at or past the leaf count).
// Output: rsp_valid is high for one cycle with rsp_data: root maximum, lowest
// leaf index holding it, and the error flag. The receiver cannot stall.
// Config: csr_valid/csr_ready write the leaf count (accepted only when idle).
// Per item: the leaf write, then a climb that rescans each level's group of
// siblings and writes their maximum into the parent node, then a descent from
// the root that follows the lowest-index child holding the wanted value; a
// flagged beat skips the climb. One item at a time; the single-port node RAM,
// read once per cycle, sets the pace.
// Reset and every leaf count write start a clearing pass over all 2*LEAVES
// words of the node RAM, then a level-shape pass that sets each inner level's
// size and base; busy stays high meanwhile.
module eight_way_max_tournament_tree
   import ttm_pkg::*;
#(
   parameter int LEAVES = 1024,
   parameter int FANOUT = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   ttm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .rsp_valid(rsp_valid),
      .sts      (sts),
      .cmd      (cmd)
   );

   ttm_dp #(
      .LEAVES(LEAVES),
      .FANOUT(FANOUT)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .sts     (sts),
      .req_data(req_data),
      .csr_data(csr_data),
      .rsp_data(rsp_data)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb
   import ttm_pkg::*;
();

   localparam int LEAF_MAX = 1024;
   localparam int SETTLE_CYCLES = 400;
   localparam longint CYCLE_LIMIT = 4000000;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data;

   eight_way_max_tournament_tree uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   logic [VAL_W-1:0] leaf_mem [LEAF_MAX];
   int unsigned      active_leaves;
   req_type          pending_beats[$];
   rsp_type          expected_tops[$];
   int unsigned      sender_idle_pct;
   int unsigned      errors;
   int unsigned      beats_sent;
   int unsigned      results_seen;
   int unsigned      flagged_seen;
   int unsigned      count_writes;
   longint           cycles;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic void set_leaf_count(logic [CNT_W-1:0] v);
      active_leaves = (v == 0) ? 1 : (v > LEAF_MAX) ? LEAF_MAX : v;
      for (int i = 0; i < LEAF_MAX; i++) leaf_mem[i] = '0;
   endfunction

   function automatic rsp_type tree_update(req_type r);
      rsp_type e;
      e = '0;
      if (r.leaf_index >= active_leaves) begin
         e.index_error = 1'b1;
      end else begin
         leaf_mem[r.leaf_index] = r.new_value;
      end
      for (int i = 0; i < active_leaves; i++) begin
         if (leaf_mem[i] > e.top_value) begin
            e.top_value = leaf_mem[i];
            e.top_index = IDX_W'(i);
         end
      end
      return e;
   endfunction

   // driver: start stays high until the beat is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_tops.push_back(tree_update(req_data));
            beats_sent++;
         end
         if (!start || !busy) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data <= pending_beats.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_data.index_error) flagged_seen++;
         if (expected_tops.size() == 0) begin
            $error("unexpected result beat: %p", rsp_data);
            errors++;
         end else begin
            e = expected_tops.pop_front();
            if (rsp_data.top_index !== e.top_index) begin
               $error("top_index: expected %0d, got %0d", e.top_index, rsp_data.top_index);
               errors++;
            end
            if (rsp_data.top_value !== e.top_value) begin
               $error("top_value: expected %0h, got %0h", e.top_value, rsp_data.top_value);
               errors++;
            end
            if (rsp_data.index_error !== e.index_error) begin
               $error("index_error: expected %0b, got %0b", e.index_error,
                      rsp_data.index_error);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic add_beat(int unsigned idx, logic [VAL_W-1:0] val);
      req_type r;
      r.leaf_index = IDX_W'(idx);
      r.new_value = val;
      pending_beats.push_back(r);
   endtask

   task automatic drain();
      while (pending_beats.size() > 0 || start || expected_tops.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_leaf_count(logic [CNT_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      set_leaf_count(v);
      count_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic add_random_beats(int unsigned n);
      int unsigned idx;
      logic [VAL_W-1:0] val;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(9) < 8) idx = $urandom_range(active_leaves - 1);
         else idx = $urandom_range(LEAF_MAX - 1);
         case ($urandom_range(3))
            0: val = VAL_W'($urandom_range(15));
            1: val = {VAL_W{1'b1}} - VAL_W'($urandom_range(3));
            default: val = VAL_W'($urandom);
         endcase
         add_beat(idx, val);
      end
   endtask

   initial begin
      logic [CNT_W-1:0] counts[11];
      int unsigned      idle_sel[4];
      counts = '{CNT_RESET, 11'd1, 11'd0, 11'd2047, 11'd9, 11'd64, 11'd65,
                 11'd1000, 11'd1024, 11'd7, 11'd512};
      idle_sel = '{0, 85, 0, 20};
      errors = 0;
      beats_sent = 0;
      results_seen = 0;
      flagged_seen = 0;
      count_writes = 0;
      cycles = 0;
      sender_idle_pct = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_data = '0;
      set_leaf_count(CNT_RESET);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tree, extremes, ties, max replaced
      add_beat(0, '0);
      add_beat(1023, {VAL_W{1'b1}});
      add_beat(0, {VAL_W{1'b1}});
      add_beat(5, 31'h5555_5555);
      add_beat(682, 31'h2AAA_AAAA);
      add_beat(341, 31'h5555_5555);
      add_beat(0, '0);
      add_beat(1023, '0);
      add_beat(5, 31'd3);
      add_beat(7, 31'h5555_5555);
      add_beat(341, '0);

      for (int p = 0; p < 11; p++) begin
         if (p > 0) begin
            drain();
            write_leaf_count(counts[p]);
         end
         sender_idle_pct = idle_sel[p % 4];
         if (p == 4) begin
            // nine leaves: edges of range and rejected indexes
            add_beat(8, 31'd100);
            add_beat(9, 31'd500);
            add_beat(1023, 31'd600);
            add_beat(0, 31'd100);
            add_beat(8, 31'd1);
         end
         add_random_beats(130);
      end
      drain();

      $display("%0d update beats over %0d leaf count settings, %0d results checked",
               beats_sent, count_writes + 1, results_seen);
      $display("%0d rejected indexes, sender idle phases 0/85/20 percent", flagged_seen);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ttm_pkg.sv
sv/ttm_ram.sv
sv/ttm_ctrl.sv
sv/ttm_dp.sv
sv/eight_way_max_tournament_tree.sv
tb/tb.sv
